// ----- hdl/lpm_pkg.sv -----
`timescale 1ns / 1ps

package lpm_pkg;

    localparam int AddrW = 32;
    localparam int SlotW = 6;
    localparam int LenW = 6;
    localparam logic [LenW-1:0] MaxLen = LenW'(32);
    localparam int TableEntriesDefault = 64;

    typedef enum logic
    {
        FUNC_WRITE = 1'b0,
        FUNC_LOOKUP = 1'b1
    } func_t;

    // One beat as it travels along the row of cells. The address field holds
    // the prefix for a write and the query for a lookup.
    typedef struct packed
    {
        logic valid;
        func_t func;
        logic [SlotW-1:0] slot;
        logic entry_valid;
        logic [AddrW-1:0] addr;
        logic [LenW-1:0] len;
        logic found;
        logic [SlotW-1:0] best_slot;
        logic [LenW-1:0] best_len;
    } lpm_item_t;

    typedef struct packed
    {
        logic found;
        logic [SlotW-1:0] match_slot;
        logic [LenW-1:0] match_len;
    } lpm_rsp_t;

endpackage

// ----- hdl/lpm_in_if.sv -----
`timescale 1ns / 1ps

interface lpm_in_if;

    logic valid;
    logic ready;
    lpm_pkg::func_t func;
    logic [lpm_pkg::SlotW-1:0] entry_slot;
    logic entry_valid;
    logic [lpm_pkg::AddrW-1:0] prefix_addr;
    logic [lpm_pkg::LenW-1:0] prefix_len;
    logic [lpm_pkg::AddrW-1:0] query_addr;

    modport source
    (
        output valid, func, entry_slot, entry_valid, prefix_addr, prefix_len, query_addr,
        input ready
    );

    modport sink
    (
        input valid, func, entry_slot, entry_valid, prefix_addr, prefix_len, query_addr,
        output ready
    );

endinterface

// ----- hdl/lpm_out_if.sv -----
`timescale 1ns / 1ps

interface lpm_out_if;

    logic valid;
    logic ready;
    logic found;
    logic [lpm_pkg::SlotW-1:0] match_slot;
    logic [lpm_pkg::LenW-1:0] match_len;

    modport source
    (
        output valid, found, match_slot, match_len,
        input ready
    );

    modport sink
    (
        input valid, found, match_slot, match_len,
        output ready
    );

endinterface

// ----- hdl/lpm_cell.sv -----
`timescale 1ns / 1ps

module lpm_cell #(
    parameter int SLOT = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  lpm_pkg::lpm_item_t  item_in,
    output lpm_pkg::lpm_item_t  item_out
);

    localparam int SlotW = lpm_pkg::SlotW;
    localparam int AddrW = lpm_pkg::AddrW;
    localparam int LenW = lpm_pkg::LenW;
    localparam bit Writable = (SLOT < (1 << SlotW));
    localparam logic [SlotW-1:0] SlotId = SlotW'(SLOT);

    lpm_pkg::lpm_item_t item_reg, item_next;
    logic mark_reg, mark_next;
    logic [AddrW-1:0] prefix_reg, prefix_next;
    logic [LenW-1:0] len_reg, len_next;

    logic wr_hit;
    logic [AddrW-1:0] mask;
    logic hit;

    always_comb
    begin
        wr_hit = Writable && item_in.valid && (item_in.func == lpm_pkg::FUNC_WRITE)
                 && (item_in.slot == SlotId);
        mask = ~({AddrW{1'b1}} >> len_reg);
        hit = mark_reg && (((item_in.addr ^ prefix_reg) & mask) == '0);

        item_next = item_in;
        if (item_in.valid && (item_in.func == lpm_pkg::FUNC_LOOKUP) && hit
            && (!item_in.found || (len_reg > item_in.best_len)))
        begin
            item_next.found = 1'b1;
            item_next.best_slot = SlotId;
            item_next.best_len = len_reg;
        end

        mark_next = mark_reg;
        prefix_next = prefix_reg;
        len_next = len_reg;
        if (wr_hit)
        begin
            mark_next = item_in.entry_valid;
            prefix_next = item_in.addr;
            len_next = item_in.len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
            mark_reg <= 1'b0;
        end
        else if (advance)
        begin
            item_reg <= item_next;
            mark_reg <= mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prefix_reg <= prefix_next;
            len_reg <= len_next;
        end
    end

    assign item_out = item_reg;

endmodule

// ----- hdl/lpm_out_buf.sv -----
`timescale 1ns / 1ps

module lpm_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  lpm_pkg::lpm_item_t  tail,
    output logic                room,
    lpm_out_if.source           rsp
);

    lpm_pkg::lpm_rsp_t main_reg, main_next;
    lpm_pkg::lpm_rsp_t skid_reg, skid_next;
    logic main_valid_reg, main_valid_next;
    logic skid_valid_reg, skid_valid_next;

    logic push;
    logic pop;
    lpm_pkg::lpm_rsp_t tail_rsp;

    always_comb
    begin
        tail_rsp.found = tail.found;
        tail_rsp.match_slot = tail.best_slot;
        tail_rsp.match_len = tail.best_len;

        push = !skid_valid_reg && tail.valid && (tail.func == lpm_pkg::FUNC_LOOKUP);
        pop = main_valid_reg && rsp.ready;

        main_next = main_reg;
        skid_next = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;

        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next = tail_rsp;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next = tail_rsp;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign room = !skid_valid_reg;
    assign rsp.valid = main_valid_reg;
    assign rsp.found = main_reg.found;
    assign rsp.match_slot = main_reg.match_slot;
    assign rsp.match_len = main_reg.match_len;

endmodule

// ----- hdl/longest_prefix_match_core.sv -----
`timescale 1ns / 1ps

// A lookup beat passes through one cell register per table slot, then the output register.
// Throughput: one beat per cycle while the output skid register is empty.
// A stalled result holds the whole row once the output skid register fills.
// Reset clears the valid marks and all beat valids; stored prefixes and lengths
// are undefined until written.
module longest_prefix_match_core #(
    parameter int TABLE_ENTRIES = lpm_pkg::TableEntriesDefault
) (
    input  logic       clk,
    input  logic       rst_n,
    lpm_in_if.sink     req,
    lpm_out_if.source  rsp
);

    lpm_pkg::lpm_item_t chain [TABLE_ENTRIES+1];
    logic advance;

    always_comb
    begin
        chain[0].valid = req.valid;
        chain[0].func = req.func;
        chain[0].slot = req.entry_slot;
        chain[0].entry_valid = req.entry_valid;
        chain[0].addr = (req.func == lpm_pkg::FUNC_LOOKUP) ? req.query_addr : req.prefix_addr;
        chain[0].len = (req.prefix_len > lpm_pkg::MaxLen) ? lpm_pkg::MaxLen : req.prefix_len;
        chain[0].found = 1'b0;
        chain[0].best_slot = '0;
        chain[0].best_len = '0;
    end

    assign req.ready = advance;

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        lpm_cell #(
            .SLOT(i)
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .advance(advance),
            .item_in(chain[i]),
            .item_out(chain[i+1])
        );
    end

    lpm_out_buf u_out_buf (
        .clk(clk),
        .rst_n(rst_n),
        .tail(chain[TABLE_ENTRIES]),
        .room(advance),
        .rsp(rsp)
    );

`ifndef ASSERT_OFF
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |-> rsp.valid)
        else $error("row stalled with no result pending");

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.found) |-> (rsp.match_slot == '0 && rsp.match_len == '0))
        else $error("miss result carries a nonzero slot or length");

    a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.found) |-> (rsp.match_len <= lpm_pkg::MaxLen))
        else $error("match length beyond the address width");
`endif

endmodule

// ----- bench/longest_prefix_match_core_tb.sv -----
`timescale 1ns / 1ps

module longest_prefix_match_core_tb;

    import lpm_pkg::*;

    localparam int TABLE_SLOTS = 64;
    localparam int LOOKUP_LATENCY = TABLE_SLOTS + 1;
    localparam int RANDOM_BEATS = 130;

    typedef struct
    {
        func_t func;
        logic [SlotW-1:0] entry_slot;
        logic entry_valid;
        logic [AddrW-1:0] prefix_addr;
        logic [LenW-1:0] prefix_len;
        logic [AddrW-1:0] query_addr;
    } route_beat_t;

    logic clk;
    logic rst_n;

    lpm_in_if req_bus();
    lpm_out_if rsp_bus();

    longest_prefix_match_core #(
        .TABLE_ENTRIES(TABLE_SLOTS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_bus),
        .rsp(rsp_bus)
    );

    logic [AddrW-1:0] route_prefix [TABLE_SLOTS];
    logic [LenW-1:0] route_len [TABLE_SLOTS];
    bit route_on [TABLE_SLOTS];
    logic [AddrW-1:0] base_pool [4];

    lpm_rsp_t expected_matches [$];

    int send_idle_pct;
    int recv_idle_pct;
    int error_count = 0;
    int writes_sent;
    int lookups_sent;
    int hits_seen = 0;
    int misses_seen = 0;

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_bus.ready <= 1'b0;
        else
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [AddrW-1:0] lead_mask(input logic [LenW-1:0] len);
        if (len == '0)
            return '0;
        return {AddrW{1'b1}} << (AddrW - int'(len));
    endfunction

    function automatic lpm_rsp_t longest_match(input logic [AddrW-1:0] query);
        lpm_rsp_t best;
        best = '0;
        for (int s = 0; s < TABLE_SLOTS; s++)
        begin
            if (route_on[s] && ((query ^ route_prefix[s]) & lead_mask(route_len[s])) == '0
                && (!best.found || route_len[s] > best.match_len))
            begin
                best.found = 1'b1;
                best.match_slot = SlotW'(s);
                best.match_len = route_len[s];
            end
        end
        return best;
    endfunction

    function automatic route_beat_t make_write(input logic [SlotW-1:0] slot, input logic on,
                                               input logic [AddrW-1:0] addr,
                                               input logic [LenW-1:0] len);
        route_beat_t beat;
        beat.func = FUNC_WRITE;
        beat.entry_slot = slot;
        beat.entry_valid = on;
        beat.prefix_addr = addr;
        beat.prefix_len = len;
        beat.query_addr = $urandom;
        return beat;
    endfunction

    function automatic route_beat_t make_lookup(input logic [AddrW-1:0] query);
        route_beat_t beat;
        beat.func = FUNC_LOOKUP;
        beat.entry_slot = SlotW'($urandom_range(63));
        beat.entry_valid = 1'($urandom_range(1));
        beat.prefix_addr = $urandom;
        beat.prefix_len = LenW'($urandom_range(63));
        beat.query_addr = query;
        return beat;
    endfunction

    function automatic route_beat_t random_write();
        logic [AddrW-1:0] addr;
        logic [LenW-1:0] len;
        int pick;
        pick = $urandom_range(99);
        if (pick < 3)
            len = '0;
        else if (pick < 10)
            len = LenW'($urandom_range(63, 33));
        else
            len = LenW'($urandom_range(32, 1));
        if ($urandom_range(99) < 10)
            addr = $urandom;
        else
            addr = base_pool[$urandom_range(3)] ^ ($urandom >> $urandom_range(31, 8));
        return make_write(SlotW'($urandom_range(63)), $urandom_range(99) < 85, addr, len);
    endfunction

    function automatic route_beat_t random_lookup();
        int live [$];
        int s;
        logic [AddrW-1:0] mask;
        logic [AddrW-1:0] query;
        query = $urandom;
        for (int i = 0; i < TABLE_SLOTS; i++)
            if (route_on[i])
                live.push_back(i);
        if (live.size() != 0 && $urandom_range(99) < 75)
        begin
            s = live[$urandom_range(live.size() - 1)];
            mask = lead_mask(route_len[s]);
            query = (route_prefix[s] & mask) | (query & ~mask);
            // A flip of the last prefix bit makes a near miss for this route.
            if (route_len[s] != '0 && $urandom_range(99) < 20)
                query[AddrW - int'(route_len[s])] = ~query[AddrW - int'(route_len[s])];
        end
        return make_lookup(query);
    endfunction

    task automatic send_beat(input route_beat_t beat);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.func <= beat.func;
        req_bus.entry_slot <= beat.entry_slot;
        req_bus.entry_valid <= beat.entry_valid;
        req_bus.prefix_addr <= beat.prefix_addr;
        req_bus.prefix_len <= beat.prefix_len;
        req_bus.query_addr <= beat.query_addr;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        if (beat.func == FUNC_WRITE)
        begin
            route_prefix[beat.entry_slot] = beat.prefix_addr;
            route_len[beat.entry_slot] = (beat.prefix_len > MaxLen) ? MaxLen : beat.prefix_len;
            route_on[beat.entry_slot] = beat.entry_valid;
            writes_sent++;
        end
        else
        begin
            expected_matches.push_back(longest_match(beat.query_addr));
            lookups_sent++;
        end
    endtask

    task automatic wait_for_results();
        req_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_matches.size() != 0);
    endtask

    always @(posedge clk)
    begin
        lpm_rsp_t want;
        if (rsp_bus.valid && rsp_bus.ready)
        begin
            if (expected_matches.size() == 0)
            begin
                $error("Result beat arrived with no lookup outstanding.");
                error_count++;
            end
            else
            begin
                want = expected_matches.pop_front();
                if (rsp_bus.found !== want.found)
                begin
                    $error("found: expected %0d, actual %0d", want.found, rsp_bus.found);
                    error_count++;
                end
                if (rsp_bus.match_slot !== want.match_slot)
                begin
                    $error("match_slot: expected %0d, actual %0d",
                           want.match_slot, rsp_bus.match_slot);
                    error_count++;
                end
                if (rsp_bus.match_len !== want.match_len)
                begin
                    $error("match_len: expected %0d, actual %0d",
                           want.match_len, rsp_bus.match_len);
                    error_count++;
                end
                if (want.found)
                    hits_seen++;
                else
                    misses_seen++;
            end
        end
    end

    task automatic test_empty_table();
        send_beat(make_lookup(32'h0000_0000));
        send_beat(make_lookup(32'hFFFF_FFFF));
    endtask

    task automatic test_host_route();
        send_beat(make_write(6'd63, 1'b1, 32'hFFFF_FFFF, 6'd32));
        send_beat(make_lookup(32'hFFFF_FFFF));
        send_beat(make_lookup(32'hFFFF_FFFE));
    endtask

    task automatic test_default_route();
        send_beat(make_write(6'd0, 1'b1, 32'hDEAD_BEEF, 6'd0));
        send_beat(make_lookup(32'h1234_5678));
        send_beat(make_lookup(32'hFFFF_FFFE));
    endtask

    task automatic test_length_saturation();
        send_beat(make_write(6'd10, 1'b1, 32'h0A00_0000, 6'd63));
        send_beat(make_lookup(32'h0A00_0000));
        send_beat(make_write(6'd11, 1'b1, 32'h0B00_0001, 6'd33));
        send_beat(make_lookup(32'h0B00_0001));
    endtask

    task automatic test_longest_and_tie();
        send_beat(make_write(6'd20, 1'b1, 32'h0A01_0000, 6'd16));
        send_beat(make_write(6'd5, 1'b1, 32'h0A01_FFFF, 6'd16));
        send_beat(make_write(6'd30, 1'b1, 32'h0A01_0200, 6'd24));
        send_beat(make_lookup(32'h0A01_0203));
        send_beat(make_lookup(32'h0A01_0909));
    endtask

    task automatic test_remove_slot();
        send_beat(make_write(6'd5, 1'b0, 32'h0A01_0000, 6'd16));
        send_beat(make_lookup(32'h0A01_0909));
        send_beat(make_write(6'd0, 1'b0, 32'h0000_0000, 6'd0));
        send_beat(make_lookup(32'h1234_5678));
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        foreach (base_pool[i])
            base_pool[i] = $urandom;
        repeat (RANDOM_BEATS)
        begin
            if ($urandom_range(99) < 40)
                send_beat(random_write());
            else
                send_beat(random_lookup());
        end
        wait_for_results();
    endtask

    initial
    begin
        writes_sent = 0;
        lookups_sent = 0;
        send_idle_pct = 9;
        recv_idle_pct = 75;
        foreach (route_on[i])
            route_on[i] = 1'b0;
        rst_n <= 1'b0;
        req_bus.valid <= 1'b0;
        req_bus.func <= FUNC_WRITE;
        req_bus.entry_slot <= '0;
        req_bus.entry_valid <= 1'b0;
        req_bus.prefix_addr <= '0;
        req_bus.prefix_len <= '0;
        req_bus.query_addr <= '0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_host_route();
        test_default_route();
        test_length_saturation();
        test_longest_and_tie();
        test_remove_slot();
        wait_for_results();

        test_random_traffic(9, 75);
        test_random_traffic(75, 9);
        test_random_traffic(0, 0);

        repeat (2 * LOOKUP_LATENCY)
            @(posedge clk);

        $display("Covered %0d table writes and %0d lookups: %0d hit a route, %0d missed.",
                 writes_sent, lookups_sent, hits_seen, misses_seen);
        $display("Traffic ran with a stalling receiver, then an idle sender, then at full rate.");
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
